### rtl/dlq_pkg.sv
// Package for the delta-list timed wait queue.
// Holds sizing constants, request and status codes, payload structs and the
// controller/datapath command and status types. Depends on nothing.
package dlq_pkg;

  localparam int MAX_WAITERS = 16;
  localparam int TIME_BITS   = 16;
  localparam int IDX_W       = $clog2(MAX_WAITERS);
  localparam int HEAD_W      = $clog2(MAX_WAITERS + 1);
  localparam int CNT_W       = HEAD_W;

  localparam logic [HEAD_W-1:0] EMPTY_MARK = HEAD_W'(MAX_WAITERS);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_FIND   = 2'd2;

  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  thread_id;
    logic [15:0] wait_time;
    logic [7:0]  semaphore_id;
  } dlq_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] found_thread;
    logic [7:0] found_semaphore;
  } dlq_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_WR_NEW,
    S_WR_LINK,
    S_WR_RM,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic stop;
    logic wr_new;
    logic wr_link;
    logic wr_rm;
    logic finish;
  } dlq_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       full;
    logic       walk_more;
    logic       hit;
    logic       out_busy;
  } dlq_stat_t;

endpackage

### rtl/dlq_chan_if.sv
// Valid/ready channel interfaces for requests and responses of the wait queue.
// Depends on dlq_pkg for the payload structs.
interface dlq_req_if;
  logic             valid;
  logic             ready;
  dlq_pkg::dlq_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dlq_rsp_if;
  logic             valid;
  logic             ready;
  dlq_pkg::dlq_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/delta_list_timed_wait_queue.sv
// Top level of the delta-list timed wait queue: controller plus datapath.
// Depends on dlq_pkg, dlq_chan_if, dlq_ctrl and dlq_datapath.
//
// The block keeps up to MAX_WAITERS threads in a list ordered by timeout, each
// entry holding its time as a difference to the entry before it. It takes one
// request at a time: a transaction is accepted, the list is then walked one
// entry per cycle from the head (the entry memories have registered reads, so
// each cycle's read address comes from the previous read), an insert then
// writes the new entry and relinks, a remove unlinks its entry, and the
// response register is loaded last. An insert into a full store skips the
// walk. The response register lets the next request be accepted while a
// response waits to be taken. No clearing pass is needed after reset.
module delta_list_timed_wait_queue import dlq_pkg::*; (
  input  logic clk,
  input  logic rst,
  dlq_req_if.sink   req,
  dlq_rsp_if.source rsp
);

  dlq_cmd_t  cmd;
  dlq_stat_t stat;

  dlq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dlq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (req.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (rsp.data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready)
  );

  // At most one datapath operation is commanded in any cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.stop, cmd.wr_new, cmd.wr_link, cmd.wr_rm,
              cmd.finish}))
    else $error("more than one datapath command at once");

  // An accepted transaction keeps the request channel closed in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while a transaction is in progress");

  // A new entry is always followed by the relink write.
  a_new_then_link: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_new |=> cmd.wr_link)
    else $error("insert did not relink its new entry");

  // The response register is only loaded when it is free or being drained.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(rsp.valid && !rsp.ready))
    else $error("response overwritten before it was taken");

endmodule

### rtl/dlq_datapath.sv
// Datapath of the wait queue: entry memories, free-slot stack, walk registers,
// list head and count, and the response register. Depends on dlq_pkg.
module dlq_datapath import dlq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  dlq_req_t  in_data,
  input  dlq_cmd_t  cmd,
  output dlq_stat_t stat,
  output dlq_rsp_t  out_data,
  output logic      out_valid,
  input  logic      out_ready
);

  logic [7:0]           mem_thread [MAX_WAITERS];
  logic [7:0]           mem_sem    [MAX_WAITERS];
  logic [TIME_BITS-1:0] mem_delta  [MAX_WAITERS];
  logic [IDX_W-1:0]     mem_next   [MAX_WAITERS];
  logic [IDX_W-1:0]     mem_free   [MAX_WAITERS];

  logic [7:0]           rd_thread;
  logic [7:0]           rd_sem;
  logic [TIME_BITS-1:0] rd_delta;
  logic [IDX_W-1:0]     rd_next;
  logic [IDX_W-1:0]     rd_free;

  logic [HEAD_W-1:0]    head;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     sp;
  logic [CNT_W-1:0]     fill;

  dlq_req_t             req_q;
  logic [TIME_BITS-1:0] t_q;
  logic                 full_q;
  logic [IDX_W-1:0]     cur;
  logic [IDX_W-1:0]     prev;
  logic                 has_prev;
  logic [CNT_W-1:0]     steps;
  logic                 found;
  logic [TIME_BITS-1:0] hold_delta;
  logic [7:0]           hold_sem;
  logic [IDX_W-1:0]     at_next;

  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     free_raddr;
  logic [IDX_W-1:0]     alloc;
  logic                 has_succ;

  logic                 delta_we;
  logic [IDX_W-1:0]     delta_waddr;
  logic [TIME_BITS-1:0] delta_wdata;
  logic                 next_we;
  logic [IDX_W-1:0]     next_waddr;
  logic [IDX_W-1:0]     next_wdata;

  logic [1:0]           status_next;
  logic [7:0]           sem_next;

  assign rd_addr    = cmd.load ? head[IDX_W-1:0] : rd_next;
  assign free_raddr = IDX_W'(sp - CNT_W'(1));
  assign alloc      = (sp != '0) ? rd_free : fill[IDX_W-1:0];
  assign has_succ   = steps > CNT_W'(1);

  assign stat.req       = req_q.req_type;
  assign stat.full      = full_q;
  assign stat.hit       = steps != '0;
  assign stat.out_busy  = out_valid && !out_ready;
  assign stat.walk_more = (steps != '0) &&
                          ((req_q.req_type == REQ_INSERT) ? (rd_delta <= t_q)
                                                          : (rd_thread != req_q.thread_id));

  always_comb begin
    delta_we    = 1'b0;
    delta_waddr = alloc;
    delta_wdata = t_q;
    next_we     = 1'b0;
    next_waddr  = alloc;
    next_wdata  = found ? cur : '0;
    if (cmd.wr_new) begin
      delta_we = 1'b1;
      next_we  = 1'b1;
    end else if (cmd.wr_link) begin
      delta_we    = found;
      delta_waddr = cur;
      delta_wdata = hold_delta - t_q;
      next_we     = has_prev;
      next_waddr  = prev;
      next_wdata  = alloc;
    end else if (cmd.wr_rm) begin
      delta_we    = has_succ;
      delta_waddr = at_next;
      delta_wdata = rd_delta + hold_delta;
      next_we     = has_prev;
      next_waddr  = prev;
      next_wdata  = at_next;
    end
  end

  always_comb begin
    case (req_q.req_type) inside
      REQ_INSERT:           status_next = full_q ? STAT_FULL : STAT_DONE;
      REQ_REMOVE, REQ_FIND: status_next = found ? STAT_DONE : STAT_NOT_FOUND;
      default:              status_next = STAT_NOT_FOUND;
    endcase
    sem_next = (req_q.req_type == REQ_FIND && found) ? hold_sem : 8'd0;
  end

  always_ff @(posedge clk) begin
    rd_thread <= mem_thread[rd_addr];
    rd_sem    <= mem_sem[rd_addr];
    rd_delta  <= mem_delta[rd_addr];
    rd_next   <= mem_next[rd_addr];
    rd_free   <= mem_free[free_raddr];
    if (cmd.wr_new) begin
      mem_thread[alloc] <= req_q.thread_id;
      mem_sem[alloc]    <= req_q.semaphore_id;
    end
    if (delta_we) begin
      mem_delta[delta_waddr] <= delta_wdata;
    end
    if (next_we) begin
      mem_next[next_waddr] <= next_wdata;
    end
    if (cmd.wr_rm) begin
      mem_free[sp[IDX_W-1:0]] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q    <= in_data;
      t_q      <= TIME_BITS'(in_data.wait_time);
      full_q   <= count == CNT_W'(MAX_WAITERS);
      cur      <= head[IDX_W-1:0];
      has_prev <= 1'b0;
      steps    <= count;
      found    <= 1'b0;
    end
    if (cmd.step) begin
      if (req_q.req_type == REQ_INSERT) begin
        t_q <= t_q - rd_delta;
      end
      prev     <= cur;
      has_prev <= 1'b1;
      cur      <= rd_next;
      steps    <= steps - CNT_W'(1);
    end
    if (cmd.stop) begin
      found      <= steps != '0;
      hold_delta <= rd_delta;
      hold_sem   <= rd_sem;
      at_next    <= rd_next;
    end
    if (cmd.finish) begin
      out_data.status          <= status_next;
      out_data.found_thread    <= req_q.thread_id;
      out_data.found_semaphore <= sem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= EMPTY_MARK;
      count     <= '0;
      sp        <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.wr_link) begin
        if (!has_prev) begin
          head <= HEAD_W'(alloc);
        end
        count <= count + CNT_W'(1);
        if (sp != '0) begin
          sp <= sp - CNT_W'(1);
        end else begin
          fill <= fill + CNT_W'(1);
        end
      end
      if (cmd.wr_rm) begin
        if (count == CNT_W'(1)) begin
          head <= EMPTY_MARK;
        end else if (!has_prev) begin
          head <= has_succ ? HEAD_W'(at_next) : EMPTY_MARK;
        end
        count <= count - CNT_W'(1);
        sp    <= sp + CNT_W'(1);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/dlq_ctrl.sv
// Controller of the wait queue: sequences accept, list walk, link writes and
// the response hand-off. Depends on dlq_pkg.
module dlq_ctrl import dlq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dlq_stat_t stat,
  output dlq_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        case (stat.req)
          REQ_INSERT: begin
            if (stat.full) begin
              state_next = S_FIN;
            end else if (!stat.walk_more) begin
              state_next = S_WR_NEW;
            end
          end
          REQ_REMOVE: begin
            if (!stat.walk_more) begin
              state_next = stat.hit ? S_WR_RM : S_FIN;
            end
          end
          REQ_FIND: begin
            if (!stat.walk_more) begin
              state_next = S_FIN;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_WR_NEW:  state_next = S_WR_LINK;
      S_WR_LINK: state_next = S_FIN;
      S_WR_RM:   state_next = S_FIN;
      S_FIN: begin
        if (!stat.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_WALK: begin
        case (stat.req) inside
          REQ_INSERT: begin
            if (!stat.full) begin
              cmd.step = stat.walk_more;
              cmd.stop = !stat.walk_more;
            end
          end
          REQ_REMOVE, REQ_FIND: begin
            cmd.step = stat.walk_more;
            cmd.stop = !stat.walk_more;
          end
          default: cmd = '0;
        endcase
      end
      S_WR_NEW:  cmd.wr_new  = 1'b1;
      S_WR_LINK: cmd.wr_link = 1'b1;
      S_WR_RM:   cmd.wr_rm   = 1'b1;
      S_FIN:     cmd.finish  = !stat.out_busy;
      default:   cmd = '0;
    endcase
  end

endmodule
